FILE: sv/swhs_pkg.sv
// Shared types and constants of the single-wire humidity sensor reader.
// Used by the register block, the protocol engine and the top level.
package swhs_pkg;

    localparam int unsigned DataBits = 40;
    localparam int unsigned BitCntW  = 6;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_START_LOW  = 3'd1;
    localparam logic [2:0] PH_START_HIGH = 3'd2;
    localparam logic [2:0] PH_RESPONSE   = 3'd3;
    localparam logic [2:0] PH_READ       = 3'd4;

    localparam logic [1:0] REG_POLL_PERIOD = 2'd0;
    localparam logic [1:0] REG_START_LOW   = 2'd1;
    localparam logic [1:0] REG_RESP_THRESH = 2'd2;
    localparam logic [1:0] REG_BIT_THRESH  = 2'd3;

    localparam logic [15:0] POLL_PERIOD_RST = 16'd2000;
    localparam logic [7:0]  START_LOW_RST   = 8'd18;
    localparam logic [15:0] RESP_THRESH_RST = 16'd100;
    localparam logic [15:0] BIT_THRESH_RST  = 16'd100;

    localparam logic [BitCntW-1:0] LAST_BIT_CNT = BitCntW'(DataBits);

    typedef struct packed {
        logic [15:0] poll_period_ms;
        logic [7:0]  low_hold_ms;
        logic [15:0] response_threshold;
        logic [15:0] bit_threshold;
    } swhs_cfg_t;

    typedef struct packed {
        logic                drive_line_low;
        logic [2:0]          phase;
        logic                reading_valid;
        logic [DataBits-1:0] data;
        logic                checksum_ok;
    } swhs_result_t;

endpackage

FILE: sv/single_wire_humidity_sensor_reader_core.sv
// Top level of the single-wire humidity sensor reader.
// Depends on swhs_pkg, swhs_cfg_regs and swhs_proto.

// Takes one word (a millisecond tick or a line edge) per clock and returns one
// result word per input word, in the cycle after acceptance, from an output
// register. The whole state update for a word is combinational logic in the
// protocol engine, so one word per cycle is sustained while m_ready stays high;
// s_ready drops only while a result waits and m_ready is low. Configure through
// the APB port (poll period at 0x0, start low at 0x4, response threshold at
// 0x8, bit threshold at 0xC) only while no word is in flight. There is no
// timeout: without a sensor answer the block waits in its phase.
module single_wire_humidity_sensor_reader_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic        s_line_level,
    input  logic [15:0] s_high_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_drive_line_low,
    output logic [2:0]  m_phase,
    output logic        m_reading_valid,
    output logic [7:0]  m_humidity_int,
    output logic [7:0]  m_humidity_dec,
    output logic [7:0]  m_temperature_int,
    output logic [7:0]  m_temperature_dec,
    output logic [7:0]  m_checksum_byte,
    output logic        m_checksum_ok
);
    import swhs_pkg::*;

    swhs_cfg_t    cfg;
    swhs_result_t result;
    swhs_result_t out_reg;
    logic         out_valid_reg;
    logic         word_en;

    assign s_ready = !out_valid_reg || m_ready;
    assign word_en = s_valid && s_ready;

    swhs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swhs_proto u_proto (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .word_en    (word_en),
        .action     (s_action),
        .line_level (s_line_level),
        .high_count (s_high_count),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (word_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (word_en) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_drive_line_low  = out_reg.drive_line_low;
    assign m_phase           = out_reg.phase;
    assign m_reading_valid   = out_reg.reading_valid;
    assign m_humidity_int    = out_reg.data[39:32];
    assign m_humidity_dec    = out_reg.data[31:24];
    assign m_temperature_int = out_reg.data[23:16];
    assign m_temperature_dec = out_reg.data[15:8];
    assign m_checksum_byte   = out_reg.data[7:0];
    assign m_checksum_ok     = out_reg.checksum_ok;

`ifndef ASSERT_OFF
    a_valid_reading_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reading_valid |-> m_phase == PH_IDLE)
        else $error("reading flagged outside idle phase");

    a_drive_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_drive_line_low == (m_phase == PH_START_LOW))
        else $error("line drive disagrees with phase");

    a_accept_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted word produced no result");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");
`endif

endmodule

FILE: sv/swhs_cfg_regs.sv
// APB-style configuration registers of the humidity sensor reader.
// Depends on swhs_pkg for register indexes, reset values and the config struct.
module swhs_cfg_regs (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output swhs_pkg::swhs_cfg_t   cfg
);
    import swhs_pkg::*;

    swhs_cfg_t  cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poll_period_ms     <= POLL_PERIOD_RST;
            cfg_reg.low_hold_ms        <= START_LOW_RST;
            cfg_reg.response_threshold <= RESP_THRESH_RST;
            cfg_reg.bit_threshold      <= BIT_THRESH_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_POLL_PERIOD: cfg_reg.poll_period_ms     <= pwdata[15:0];
                REG_START_LOW:   cfg_reg.low_hold_ms        <= pwdata[7:0];
                REG_RESP_THRESH: cfg_reg.response_threshold <= pwdata[15:0];
                REG_BIT_THRESH:  cfg_reg.bit_threshold      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POLL_PERIOD: prdata = {16'd0, cfg_reg.poll_period_ms};
            REG_START_LOW:   prdata = {24'd0, cfg_reg.low_hold_ms};
            REG_RESP_THRESH: prdata = {16'd0, cfg_reg.response_threshold};
            REG_BIT_THRESH:  prdata = {16'd0, cfg_reg.bit_threshold};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

FILE: sv/swhs_proto.sv
// Protocol engine: poll timer, start pulse, response and 40-bit data capture.
// Depends on swhs_pkg; updates its state on every accepted word.
module swhs_proto (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  swhs_pkg::swhs_cfg_t    cfg,
    input  logic                   word_en,
    input  logic                   action,
    input  logic                   line_level,
    input  logic [15:0]            high_count,
    output swhs_pkg::swhs_result_t result
);
    import swhs_pkg::*;

    logic [15:0]         poll_reg,  poll_next;
    logic [7:0]          start_reg, start_next;
    logic [2:0]          phase_reg, phase_next;
    logic [BitCntW-1:0]  bitcnt_reg, bitcnt_next;
    logic [DataBits-1:0] data_reg,  data_next;
    logic                valid_next;

    logic [16:0]         poll_inc;
    logic [8:0]          start_inc;
    logic                expired;
    logic [7:0]          sum8;

    assign poll_inc  = {1'b0, poll_reg} + 17'd1;
    assign start_inc = {1'b0, start_reg} + 9'd1;
    assign expired   = poll_inc >= {1'b0, cfg.poll_period_ms};

    always_comb begin
        poll_next   = poll_reg;
        start_next  = start_reg;
        phase_next  = phase_reg;
        bitcnt_next = bitcnt_reg;
        data_next   = data_reg;
        valid_next  = 1'b0;
        if (!action) begin
            poll_next = expired ? 16'd0 : poll_inc[15:0];
            // start-low count goes first, then the poll expiry
            if (phase_reg == PH_START_LOW) begin
                start_next = start_inc[7:0];
                if (start_inc >= {1'b0, cfg.low_hold_ms}) begin
                    phase_next = PH_START_HIGH;
                end
            end
            if (expired && phase_reg == PH_IDLE) begin
                data_next   = '0;
                bitcnt_next = '0;
                start_next  = 8'd0;
                phase_next  = PH_START_LOW;
            end
        end else if (!line_level) begin
            case (phase_reg)
                PH_START_HIGH: phase_next = PH_RESPONSE;
                PH_RESPONSE: begin
                    if (high_count > cfg.response_threshold) begin
                        phase_next  = PH_READ;
                        bitcnt_next = '0;
                    end
                end
                PH_READ: begin
                    data_next   = {data_reg[DataBits-2:0],
                                   high_count > cfg.bit_threshold};
                    bitcnt_next = bitcnt_reg + BitCntW'(1);
                    if (bitcnt_next >= LAST_BIT_CNT) begin
                        phase_next = PH_IDLE;
                        valid_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_reg   <= 16'd0;
            start_reg  <= 8'd0;
            phase_reg  <= PH_IDLE;
            bitcnt_reg <= '0;
            data_reg   <= '0;
        end else if (word_en) begin
            poll_reg   <= poll_next;
            start_reg  <= start_next;
            phase_reg  <= phase_next;
            bitcnt_reg <= bitcnt_next;
            data_reg   <= data_next;
        end
    end

    assign sum8 = data_next[39:32] + data_next[31:24] + data_next[23:16] + data_next[15:8];

    assign result.drive_line_low = (phase_next == PH_START_LOW);
    assign result.phase          = phase_next;
    assign result.reading_valid  = valid_next;
    assign result.data           = data_next;
    assign result.checksum_ok    = (sum8 == data_next[7:0]);

endmodule

FILE: tb/single_wire_humidity_sensor_reader_core_test.sv
// Testbench for single_wire_humidity_sensor_reader_core: drives ticks and line edges,
// mirrors the sensor protocol in a small class and checks every status word it returns.
// Depends on swhs_pkg and the core RTL only.
module single_wire_humidity_sensor_reader_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swhs_pkg::*;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_EDGE = 1'b1;
    localparam logic LVL_LOW  = 1'b0;
    localparam logic LVL_HIGH = 1'b1;
    localparam int   STALL_LIMIT = 5000;
    localparam int   MAX_REPORTS = 30;

    // Mirror of the protocol state plus the status words still owed by the core.
    class sensor_reader_mirror;
        logic [15:0] poll_period;
        logic [7:0]  low_ticks;
        logic [15:0] resp_thr;
        logic [15:0] bit_thr;
        logic [15:0] poll_cnt;
        logic [7:0]  start_cnt;
        logic [2:0]  phase;
        logic [5:0]  bit_cnt;
        logic [39:0] shift;
        swhs_result_t due_status[$];
        int errors;
        int words;
        int readings;
        int good_sums;

        function new();
            poll_period = POLL_PERIOD_RST;
            low_ticks   = START_LOW_RST;
            resp_thr    = RESP_THRESH_RST;
            bit_thr     = BIT_THRESH_RST;
            poll_cnt    = '0;
            start_cnt   = '0;
            phase       = PH_IDLE;
            bit_cnt     = '0;
            shift       = '0;
            errors      = 0;
            words       = 0;
            readings    = 0;
            good_sums   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_POLL_PERIOD: poll_period = value[15:0];
                REG_START_LOW:   low_ticks   = value[7:0];
                REG_RESP_THRESH: resp_thr    = value[15:0];
                REG_BIT_THRESH:  bit_thr     = value[15:0];
                default: ;
            endcase
        endfunction

        function void take_word(logic action, logic level, logic [15:0] pulse);
            logic [16:0] next_poll;
            logic [8:0]  next_start;
            logic        expired;
            logic [7:0]  sum;
            swhs_result_t want;
            want.reading_valid = 1'b0;
            words++;
            if (action == ACT_TICK) begin
                next_poll = {1'b0, poll_cnt} + 17'd1;
                expired = next_poll >= {1'b0, poll_period};
                if (expired)
                    next_poll = '0;
                poll_cnt = next_poll[15:0];
                // start-low count goes first, so a fresh request counts from the next tick
                if (phase == PH_START_LOW) begin
                    next_start = {1'b0, start_cnt} + 9'd1;
                    if (next_start >= {1'b0, low_ticks})
                        phase = PH_START_HIGH;
                    start_cnt = next_start[7:0];
                end
                if (expired && phase == PH_IDLE) begin
                    shift     = '0;
                    bit_cnt   = '0;
                    start_cnt = '0;
                    phase     = PH_START_LOW;
                end
            end else if (level == LVL_LOW) begin
                case (phase)
                    PH_START_HIGH: phase = PH_RESPONSE;
                    PH_RESPONSE: begin
                        if (pulse > resp_thr) begin
                            phase   = PH_READ;
                            bit_cnt = '0;
                        end
                    end
                    PH_READ: begin
                        shift   = {shift[38:0], pulse > bit_thr};
                        bit_cnt = bit_cnt + 6'd1;
                        if (bit_cnt >= LAST_BIT_CNT) begin
                            phase = PH_IDLE;
                            want.reading_valid = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            sum = shift[39:32] + shift[31:24] + shift[23:16] + shift[15:8];
            want.drive_line_low = (phase == PH_START_LOW);
            want.phase          = phase;
            want.data           = shift;
            want.checksum_ok    = (sum == shift[7:0]);
            if (want.reading_valid) begin
                readings++;
                if (want.checksum_ok)
                    good_sums++;
            end
            due_status.push_back(want);
        endfunction

        function void compare(string field, logic [39:0] want, logic [39:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        function void match_status(swhs_result_t got);
            swhs_result_t want;
            if (due_status.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: status word with nothing pending, got %0h", $time, got);
                return;
            end
            want = due_status.pop_front();
            compare("drive_line_low", 40'(want.drive_line_low), 40'(got.drive_line_low));
            compare("phase", 40'(want.phase), 40'(got.phase));
            compare("reading_valid", 40'(want.reading_valid), 40'(got.reading_valid));
            compare("humidity_int", 40'(want.data[39:32]), 40'(got.data[39:32]));
            compare("humidity_dec", 40'(want.data[31:24]), 40'(got.data[31:24]));
            compare("temperature_int", 40'(want.data[23:16]), 40'(got.data[23:16]));
            compare("temperature_dec", 40'(want.data[15:8]), 40'(got.data[15:8]));
            compare("checksum_byte", 40'(want.data[7:0]), 40'(got.data[7:0]));
            compare("checksum_ok", 40'(want.checksum_ok), 40'(got.checksum_ok));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic        s_line_level = 1'b0;
    logic [15:0] s_high_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_drive_line_low;
    logic [2:0]  m_phase;
    logic        m_reading_valid;
    logic [7:0]  m_humidity_int;
    logic [7:0]  m_humidity_dec;
    logic [7:0]  m_temperature_int;
    logic [7:0]  m_temperature_dec;
    logic [7:0]  m_checksum_byte;
    logic        m_checksum_ok;

    sensor_reader_mirror mirror;
    swhs_result_t seen_status;
    bit steady = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    single_wire_humidity_sensor_reader_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_line_level      (s_line_level),
        .s_high_count      (s_high_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_drive_line_low  (m_drive_line_low),
        .m_phase           (m_phase),
        .m_reading_valid   (m_reading_valid),
        .m_humidity_int    (m_humidity_int),
        .m_humidity_dec    (m_humidity_dec),
        .m_temperature_int (m_temperature_int),
        .m_temperature_dec (m_temperature_dec),
        .m_checksum_byte   (m_checksum_byte),
        .m_checksum_ok     (m_checksum_ok)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: random backpressure, a long hold-off on request, none while steady.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 80;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_status.drive_line_low = m_drive_line_low;
            seen_status.phase          = m_phase;
            seen_status.reading_valid  = m_reading_valid;
            seen_status.data           = {m_humidity_int, m_humidity_dec, m_temperature_int,
                                          m_temperature_dec, m_checksum_byte};
            seen_status.checksum_ok    = m_checksum_ok;
            mirror.match_status(seen_status);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL single_wire_humidity_sensor_reader_core");
            $finish;
        end
    end

    task automatic send_word(input logic action, input logic level, input logic [15:0] pulse);
        while (!steady && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= action;
        s_line_level <= level;
        s_high_count <= pulse;
        do @(posedge aclk); while (!s_ready);
        mirror.take_word(action, level, pulse);
    endtask

    task automatic send_noise();
        if ($urandom_range(1))
            send_word(ACT_TICK, 1'($urandom), 16'($urandom));
        else
            send_word(ACT_EDGE, LVL_HIGH, 16'($urandom));
    endtask

    task automatic noise_burst(input int count);
        logic [15:0] pulse;
        repeat (count) begin
            case ($urandom_range(3))
                0: pulse = 16'h0000;
                1: pulse = 16'hFFFF;
                default: pulse = 16'($urandom);
            endcase
            send_word(1'($urandom), 1'($urandom), pulse);
        end
    endtask

    // Wait out every pending status word with the input idle.
    task automatic drain();
        s_valid <= 1'b0;
        while (mirror.due_status.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror.set_reg(idx, value);
    endtask

    // One full exchange: request, acknowledge, response, then a 40-bit frame.
    task automatic run_measurement();
        logic [39:0] frame;
        logic [15:0] pulse;
        int k;
        while (mirror.phase != PH_START_HIGH) begin
            if (mirror.phase == PH_RESPONSE || mirror.phase == PH_READ)
                send_word(ACT_EDGE, LVL_LOW, 16'hFFFF);
            else if ($urandom_range(5) == 0)
                send_word(ACT_EDGE, 1'($urandom), 16'($urandom));
            else
                send_word(ACT_TICK, 1'($urandom), 16'($urandom));
        end
        send_word(ACT_EDGE, LVL_LOW, 16'($urandom));
        // sometimes a response that is too short first; the block must keep waiting
        if ($urandom_range(3) == 0)
            send_word(ACT_EDGE, LVL_LOW, 16'($urandom_range(mirror.resp_thr, 0)));
        send_word(ACT_EDGE, LVL_LOW, 16'($urandom_range(65535, int'(mirror.resp_thr) + 1)));
        case ($urandom_range(5))
            0: frame = '0;
            1: frame = '1;
            default: frame = {$urandom, 8'($urandom)};
        endcase
        if ($urandom_range(1))
            frame[7:0] = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
        for (k = 39; k >= 0; k--) begin
            if ($urandom_range(7) == 0)
                send_noise();
            if (frame[k] && mirror.bit_thr != 16'hFFFF)
                pulse = 16'($urandom_range(65535, int'(mirror.bit_thr) + 1));
            else
                pulse = 16'($urandom_range(mirror.bit_thr, 0));
            send_word(ACT_EDGE, LVL_LOW, pulse);
        end
    endtask

    task automatic run_phase(input logic [15:0] poll, input logic [7:0] start,
                             input logic [15:0] resp, input logic [15:0] bthr,
                             input int budget, input bit hold_first);
        int first;
        drain();
        apb_write(REG_POLL_PERIOD, {16'h0, poll});
        apb_write(REG_START_LOW, {24'h0, start});
        apb_write(REG_RESP_THRESH, {16'h0, resp});
        apb_write(REG_BIT_THRESH, {16'h0, bthr});
        if (hold_first)
            hold_request = 1'b1;
        first = mirror.words;
        while (mirror.words - first < budget) begin
            // a full exchange needs a reachable response and a short poll period
            if (resp != 16'hFFFF && poll < 16'd100 && $urandom_range(3) != 0)
                run_measurement();
            else
                noise_burst($urandom_range(1, 8));
        end
    endtask

    initial begin
        mirror = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: edges in idle do nothing, a tick only counts
        send_word(ACT_EDGE, LVL_LOW, 16'hFFFF);
        send_word(ACT_EDGE, LVL_HIGH, 16'h0000);
        send_word(ACT_TICK, LVL_HIGH, 16'hFFFF);
        drain();
        apb_write(REG_POLL_PERIOD, 32'd0);
        apb_write(REG_START_LOW, 32'd0);
        apb_write(REG_RESP_THRESH, 32'd0);
        apb_write(REG_BIT_THRESH, 32'hFFFF);
        send_word(ACT_EDGE, LVL_LOW, 16'h0000);
        send_word(ACT_TICK, LVL_LOW, 16'h0000);
        send_word(ACT_EDGE, LVL_LOW, 16'hFFFF);
        send_word(ACT_EDGE, LVL_HIGH, 16'hFFFF);
        // zero start time: released on the first tick, while the repeated request drops
        send_word(ACT_TICK, LVL_HIGH, 16'h0000);
        send_word(ACT_TICK, LVL_LOW, 16'hFFFF);
        send_word(ACT_EDGE, LVL_HIGH, 16'h1234);
        send_word(ACT_EDGE, LVL_LOW, 16'h0000);
        send_word(ACT_EDGE, LVL_LOW, 16'h0000);
        send_word(ACT_TICK, LVL_LOW, 16'h0000);
        send_word(ACT_EDGE, LVL_HIGH, 16'hFFFF);
        send_word(ACT_EDGE, LVL_LOW, 16'h0001);
        send_word(ACT_EDGE, LVL_LOW, 16'hFFFF);
        send_word(ACT_TICK, LVL_HIGH, 16'hFFFF);
        send_word(ACT_EDGE, LVL_HIGH, 16'h0000);

        run_phase(16'd0, 8'd0, 16'd0, 16'd0, 45, 1'b0);
        steady = 1'b1;
        run_phase(16'd1, 8'd1, 16'd100, 16'd100, 45, 1'b0);
        steady = 1'b0;
        run_phase(16'd7, 8'd3, 16'd1000, 16'd30000, 45, 1'b1);
        run_phase(16'd3, 8'd255, 16'd40000, 16'hFFFE, 20, 1'b0);
        run_phase(16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF, 40, 1'b0);
        run_phase(16'($urandom_range(12, 1)), 8'($urandom_range(20)),
                  16'($urandom_range(65534)), 16'($urandom), 45, 1'b0);
        run_phase(16'd20, START_LOW_RST, RESP_THRESH_RST, BIT_THRESH_RST, 45, 1'b0);
        drain();
        repeat (10) @(posedge aclk);

        $display("Covered %0d words over nine register settings, extremes included,",
                 mirror.words);
        $display("with %0d completed readings, %0d of them with a matching checksum.",
                 mirror.readings, mirror.good_sums);
        if (mirror.errors == 0 && mirror.due_status.size() == 0)
            $display("PASS single_wire_humidity_sensor_reader_core");
        else
            $display("FAIL single_wire_humidity_sensor_reader_core");
        $finish;
    end

endmodule
